// File: hw/rtl/deq_pkg.sv
// deq_pkg: opcodes, status codes, sequencer states and port widths for the
// double-ended queue. No dependencies; used by double_ended_queue_top and sim/tb_top.
package deq_pkg;

   // default sizing
   localparam int DEQ_CAPACITY   = 64;
   localparam int DEQ_ELEM_WIDTH = 32;

   // fixed port widths
   localparam int OPCODE_W = 4;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK  = 4'd0,
      OP_PUSH_FRONT = 4'd1,
      OP_POP_BACK   = 4'd2,
      OP_POP_FRONT  = 4'd3,
      OP_READ       = 4'd4,
      OP_WRITE      = 4'd5,
      OP_INSERT     = 4'd6,
      OP_ERASE      = 4'd7,
      OP_CLEAR      = 4'd8
   } deq_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } deq_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RDWAIT,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INS_WR,
      S_DONE
   } deq_state_type;

endpackage

// File: hw/rtl/deq_ram.sv
// deq_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the element store of the queue.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/deq_slot.sv
// deq_slot: circular index unit, store slot = (head + offset) mod CAPACITY.
// Shared by every store access of the sequencer. No package dependency.
module deq_slot #(
   parameter int CAPACITY = 64
) (
   input  logic [$clog2(CAPACITY)-1:0]   head,
   input  logic [$clog2(CAPACITY+1)-1:0] offset,
   output logic [$clog2(CAPACITY)-1:0]   slot
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] wrapped;

   // head and offset are both below CAPACITY, so one subtract folds the sum
   always_comb begin
      sum = SUM_W'(head) + SUM_W'(offset);
      if (sum >= SUM_W'(CAPACITY)) begin
         wrapped = sum - SUM_W'(CAPACITY);
      end else begin
         wrapped = sum;
      end
   end

   assign slot = wrapped[PTR_W-1:0];

endmodule

// File: hw/rtl/double_ended_queue_top.sv
// Double-ended queue of CAPACITY elements of ELEM_WIDTH bits, kept in a circular
// RAM with a head pointer and an element count. One item is taken at a time and
// each gives one result (element, status, new count). An error, clear or unused
// opcode goes straight to the result; push, write, pop and read make one store
// access; insert and erase shift each element behind the position, a read then
// a write, through the single RAM read and write port and the one index adder.
// The store needs no clearing after reset. The result register lets the next item
// in while a finished result is still stalled.
// Depends on deq_pkg, deq_ram and deq_slot.
module double_ended_queue_top
   import deq_pkg::*;
#(
   parameter int CAPACITY   = DEQ_CAPACITY,
   parameter int ELEM_WIDTH = DEQ_ELEM_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [POS_W-1:0]    req_position,
   input  logic [DATA_W-1:0]   req_data_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_data_out,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_element_count
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = CNT_W + 1;

   deq_state_type        state_ff, state_in;
   deq_op_type           op_ff, op_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [ELEM_WIDTH-1:0] elem_ff, elem_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     iter_ff, iter_in;
   logic [ELEM_WIDTH-1:0] res_data_ff, res_data_in;
   deq_status_type       res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   deq_status_type       rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic                  out_free;
   deq_op_type            req_op;
   deq_status_type        acc_status;
   logic [15:0]           pos16;
   logic [15:0]           cnt16;
   logic [63:0]           din64;
   logic [63:0]           dout64;

   logic                  mem_we;
   logic                  mem_re;
   logic [CNT_W-1:0]      offset;
   logic [PTR_W-1:0]      slot;
   logic [ELEM_WIDTH-1:0] mem_wdata;
   logic [ELEM_WIDTH-1:0] mem_rdata;

   assign req_op   = deq_op_type'(req_opcode);
   assign accept   = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pos16    = 16'(req_position);
   assign cnt16    = 16'(count_ff);
   assign din64    = 64'(req_data_in);
   assign dout64   = 64'(res_data_ff);

   deq_slot #(
      .CAPACITY(CAPACITY)
   ) u_slot (
      .head   (head_ff),
      .offset (offset),
      .slot   (slot)
   );

   deq_ram #(
      .WIDTH(ELEM_WIDTH),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (slot),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (slot),
      .rd_data (mem_rdata)
   );

   // checks against the count as it stands when the item arrives
   always_comb begin
      acc_status = ST_OK;
      case (req_op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (cnt16 == 16'(CAPACITY)) acc_status = ST_FULL;
         end
         OP_POP_BACK, OP_POP_FRONT: begin
            if (cnt16 == 16'd0) acc_status = ST_EMPTY;
         end
         OP_READ, OP_WRITE, OP_ERASE: begin
            if (cnt16 == 16'd0) acc_status = ST_EMPTY;
            else if (pos16 >= cnt16) acc_status = ST_RANGE;
         end
         OP_INSERT: begin
            // range is checked before fullness
            if (pos16 > cnt16) acc_status = ST_RANGE;
            else if (cnt16 == 16'(CAPACITY)) acc_status = ST_FULL;
         end
         default: acc_status = ST_OK;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (acc_status == ST_OK && (req_op inside {[OP_PUSH_BACK:OP_ERASE]})) begin
                  state_in = S_EXEC;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_POP_BACK, OP_POP_FRONT, OP_READ, OP_ERASE: state_in = S_RDWAIT;
               OP_INSERT: state_in = (count_ff > pos_ff) ? S_SHIFT_RD : S_INS_WR;
               default: state_in = S_DONE;
            endcase
         end
         S_RDWAIT: begin
            if (op_ff == OP_ERASE && (CMP_W'(pos_ff) + CMP_W'(1) < CMP_W'(count_ff))) begin
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            if (op_ff == OP_INSERT) begin
               state_in = (iter_ff - CNT_W'(1) > pos_ff) ? S_SHIFT_RD : S_INS_WR;
            end else begin
               // count already holds the reduced value here
               state_in = (CMP_W'(iter_ff) + CMP_W'(1) < CMP_W'(count_ff)) ? S_SHIFT_RD
                                                                          : S_DONE;
            end
         end
         S_INS_WR: state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // store port and index unit control
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      offset    = pos_ff;
      mem_wdata = elem_ff;
      case (state_ff)
         S_EXEC: begin
            case (op_ff)
               OP_PUSH_BACK: begin
                  mem_we = 1'b1;
                  offset = count_ff;
               end
               OP_PUSH_FRONT: begin
                  mem_we = 1'b1;
                  offset = CNT_W'(CAPACITY - 1);
               end
               OP_POP_BACK: begin
                  mem_re = 1'b1;
                  offset = count_ff - CNT_W'(1);
               end
               OP_POP_FRONT: begin
                  mem_re = 1'b1;
                  offset = '0;
               end
               OP_READ, OP_ERASE: mem_re = 1'b1;
               OP_WRITE: mem_we = 1'b1;
               default: mem_re = 1'b0;
            endcase
         end
         S_RDWAIT: offset = CNT_W'(1);
         S_SHIFT_RD: begin
            mem_re = 1'b1;
            offset = (op_ff == OP_INSERT) ? iter_ff - CNT_W'(1) : iter_ff + CNT_W'(1);
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            offset    = iter_ff;
            mem_wdata = mem_rdata;
         end
         S_INS_WR: mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   // datapath registers
   always_comb begin
      op_in         = op_ff;
      pos_in        = pos_ff;
      elem_in       = elem_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      iter_in       = iter_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               pos_in        = pos16[CNT_W-1:0];
               elem_in       = din64[ELEM_WIDTH-1:0];
               res_data_in   = '0;
               res_status_in = acc_status;
               if (req_op == OP_CLEAR) begin
                  count_in = '0;
                  head_in  = '0;
               end
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_PUSH_BACK: count_in = count_ff + CNT_W'(1);
               OP_PUSH_FRONT: begin
                  count_in = count_ff + CNT_W'(1);
                  head_in  = slot;
               end
               OP_POP_BACK, OP_POP_FRONT: count_in = count_ff - CNT_W'(1);
               OP_INSERT: iter_in = count_ff;
               default: iter_in = iter_ff;
            endcase
         end
         S_RDWAIT: begin
            res_data_in = mem_rdata;
            if (op_ff == OP_POP_FRONT) head_in = slot;
            if (op_ff == OP_ERASE) begin
               count_in = count_ff - CNT_W'(1);
               iter_in  = pos_ff;
            end
         end
         S_SHIFT_WR: begin
            iter_in = (op_ff == OP_INSERT) ? iter_ff - CNT_W'(1) : iter_ff + CNT_W'(1);
         end
         S_INS_WR: count_in = count_ff + CNT_W'(1);
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = dout64[DATA_W-1:0];
               rsp_status_in = res_status_ff;
               rsp_count_in  = cnt16[COUNT_W-1:0];
            end
         end
         default: iter_in = iter_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      elem_ff       <= elem_in;
      iter_ff       <= iter_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_out      = rsp_data_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      (PTR_W+1)'(head_ff) < (PTR_W+1)'(CAPACITY))
      else $error("head pointer outside store");

   a_no_store_access_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !mem_we && !mem_re)
      else $error("store accessed outside an operation");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised without a finished item");

endmodule

// File: sim/tb_top.sv
// Self-checking bench for double_ended_queue_top: directed table, then random phases
// (fill, drain, mixed) with a shadow deque predicting each result.
// Depends on deq_pkg and the RTL under hw/rtl.
module tb_top
   import deq_pkg::*;
();

   localparam int DEPTH = DEQ_CAPACITY;
   localparam int NUM_ITEMS = 1600;
   localparam int NUM_DIRECTED = 25;
   localparam int MAX_SHIFT_CYCLES = 4 + 2 * DEPTH;
   localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 4'd9;
   localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 4'd15;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_type;

   typedef struct packed {
      logic [DATA_W-1:0]  data;
      deq_status_type     status;
      logic [COUNT_W-1:0] count;
   } deq_result_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0]    pos;
      logic [DATA_W-1:0]   data;
      logic                typed;
      deq_result_type      want;
   } deq_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OPCODE_W-1:0] req_opcode = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [DATA_W-1:0]   req_data_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DATA_W-1:0]   rsp_data_out;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_element_count;

   // shadow copy of the deque
   logic [DATA_W-1:0] shadow_store [DEPTH];
   int unsigned       shadow_head;
   int unsigned       shadow_count;

   deq_result_type pending_results [$];
   deq_row_type    directed_rows [NUM_DIRECTED];
   int             error_count;
   int             items_sent;
   int             results_seen;
   int             burst_left;

   double_ended_queue_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_position      (req_position),
      .req_data_in       (req_data_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_out      (rsp_data_out),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch: %s", what);
   endtask

   function automatic int unsigned slot_at(input int unsigned p);
      return (shadow_head + p) % DEPTH;
   endfunction

   function automatic deq_result_type apply_deque_op(input logic [OPCODE_W-1:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [DATA_W-1:0] data);
      deq_result_type r;
      int unsigned p;
      int unsigned i;
      r.data = '0;
      r.status = ST_OK;
      p = pos;
      case (op)
         OP_PUSH_BACK: begin
            if (shadow_count >= DEPTH) r.status = ST_FULL;
            else begin
               shadow_store[slot_at(shadow_count)] = data;
               shadow_count++;
            end
         end
         OP_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) r.status = ST_FULL;
            else begin
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_store[shadow_head] = data;
               shadow_count++;
            end
         end
         OP_POP_BACK: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else begin
               r.data = shadow_store[slot_at(shadow_count - 1)];
               shadow_count--;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else begin
               r.data = shadow_store[shadow_head];
               shadow_head = (shadow_head + 1) % DEPTH;
               shadow_count--;
            end
         end
         OP_READ: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else if (p >= shadow_count) r.status = ST_RANGE;
            else r.data = shadow_store[slot_at(p)];
         end
         OP_WRITE: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else if (p >= shadow_count) r.status = ST_RANGE;
            else shadow_store[slot_at(p)] = data;
         end
         OP_INSERT: begin
            // range is checked ahead of fullness
            if (p > shadow_count) r.status = ST_RANGE;
            else if (shadow_count >= DEPTH) r.status = ST_FULL;
            else begin
               for (i = shadow_count; i > p; i--)
                  shadow_store[slot_at(i)] = shadow_store[slot_at(i - 1)];
               shadow_store[slot_at(p)] = data;
               shadow_count++;
            end
         end
         OP_ERASE: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else if (p >= shadow_count) r.status = ST_RANGE;
            else begin
               r.data = shadow_store[slot_at(p)];
               for (i = p; i + 1 < shadow_count; i++)
                  shadow_store[slot_at(i)] = shadow_store[slot_at(i + 1)];
               shadow_count--;
            end
         end
         OP_CLEAR: begin
            shadow_count = 0;
            shadow_head = 0;
         end
         default: ;
      endcase
      r.count = shadow_count[COUNT_W-1:0];
      return r;
   endfunction

   // Present one item, hold it until taken, then record what must come back.
   task automatic drive_item(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] data, input logic typed,
                             input deq_result_type want);
      deq_result_type predicted;
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_position <= pos;
      req_data_in <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_deque_op(op, pos, data);
      pending_results.insert(pending_results.size(), typed ? want : predicted);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_all_returned();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_random(input phase_type ph);
      logic [OPCODE_W-1:0] op;
      logic [POS_W-1:0]    pos;
      int r;
      r = $urandom_range(0, 99);
      case (ph)
         PH_FILL: begin
            if (r < 40) op = OP_PUSH_BACK;
            else if (r < 70) op = OP_PUSH_FRONT;
            else if (r < 95) op = OP_INSERT;
            else if (r < 98) op = OP_READ;
            else op = OPCODE_W'($urandom_range(0, OP_SPARE_LAST));
         end
         PH_DRAIN: begin
            if (r < 35) op = OP_POP_BACK;
            else if (r < 65) op = OP_POP_FRONT;
            else if (r < 95) op = OP_ERASE;
            else op = OP_READ;
         end
         default: begin
            if (r < 15) op = OP_PUSH_BACK;
            else if (r < 25) op = OP_PUSH_FRONT;
            else if (r < 35) op = OP_POP_BACK;
            else if (r < 45) op = OP_POP_FRONT;
            else if (r < 57) op = OP_READ;
            else if (r < 67) op = OP_WRITE;
            else if (r < 80) op = OP_INSERT;
            else if (r < 92) op = OP_ERASE;
            else if (r < 95) op = OP_CLEAR;
            else op = OPCODE_W'($urandom_range(0, OP_SPARE_LAST));
         end
      endcase
      // mostly live positions, some at or past the end, some anywhere
      r = $urandom_range(0, 9);
      if (r < 7) pos = POS_W'($urandom_range(0, shadow_count));
      else if (r < 9) pos = POS_W'($urandom_range(0, 2 ** POS_W - 1));
      else pos = POS_W'(shadow_count + $urandom_range(0, 1));
      drive_item(op, pos, $urandom, 1'b0, '0);
   endtask

   // result side: stall pattern and checking
   int stall_mode;
   int stall_timer;
   int stall_run;

   always @(posedge clock) begin
      deq_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (rsp_data_out !== want.data)
               report_mismatch($sformatf("result %0d data_out %h, want %h",
                                         results_seen, rsp_data_out, want.data));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, want %0d",
                                         results_seen, rsp_status, want.status));
            if (rsp_element_count !== want.count)
               report_mismatch($sformatf("result %0d element_count %0d, want %0d",
                                         results_seen, rsp_element_count, want.count));
         end
         results_seen++;
      end
      if (stall_timer == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_timer = $urandom_range(50, 300);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2: rsp_stall <= ($urandom_range(0, 7) == 0);
         default: begin
            // long runs of stalling and flowing
            if (stall_run == 0) begin
               stall_run = $urandom_range(1, 25);
               rsp_stall <= !rsp_stall;
            end else begin
               stall_run--;
            end
         end
      endcase
   end

   initial begin
      int k;
      int extra;
      int drain_cycles;
      phase_type ph;
      directed_rows = '{
         '{OP_POP_BACK,   7'd0,   32'h0000_0000, 1'b1, '{32'd0, ST_EMPTY, 7'd0}},
         '{OP_POP_FRONT,  7'd0,   32'hFFFF_FFFF, 1'b1, '{32'd0, ST_EMPTY, 7'd0}},
         '{OP_READ,       7'd0,   32'h0000_0000, 1'b1, '{32'd0, ST_EMPTY, 7'd0}},
         '{OP_WRITE,      7'd0,   32'hFFFF_FFFF, 1'b1, '{32'd0, ST_EMPTY, 7'd0}},
         '{OP_ERASE,      7'd127, 32'h0000_0000, 1'b1, '{32'd0, ST_EMPTY, 7'd0}},
         '{OP_INSERT,     7'd1,   32'h1111_1111, 1'b1, '{32'd0, ST_RANGE, 7'd0}},
         '{OP_INSERT,     7'd0,   32'hFFFF_FFFF, 1'b1, '{32'd0, ST_OK,    7'd1}},
         '{OP_PUSH_BACK,  7'd0,   32'h0000_0000, 1'b1, '{32'd0, ST_OK,    7'd2}},
         '{OP_PUSH_FRONT, 7'd127, 32'h8000_0001, 1'b1, '{32'd0, ST_OK,    7'd3}},
         '{OP_READ,       7'd0,   32'h0000_0000, 1'b1, '{32'h8000_0001, ST_OK, 7'd3}},
         '{OP_READ,       7'd3,   32'h0000_0000, 1'b1, '{32'd0, ST_RANGE, 7'd3}},
         '{OP_READ,       7'd127, 32'h0000_0000, 1'b1, '{32'd0, ST_RANGE, 7'd3}},
         '{OP_WRITE,      7'd2,   32'hA5A5_5A5A, 1'b1, '{32'd0, ST_OK,    7'd3}},
         '{OP_READ,       7'd2,   32'h0000_0000, 1'b0, '0},
         '{OP_INSERT,     7'd1,   32'h0000_1234, 1'b0, '0},
         '{OP_INSERT,     7'd4,   32'h7FFF_FFFE, 1'b0, '0},
         '{OP_INSERT,     7'd6,   32'hDEAD_0000, 1'b1, '{32'd0, ST_RANGE, 7'd5}},
         '{OP_ERASE,      7'd2,   32'h0000_0000, 1'b0, '0},
         '{OP_ERASE,      7'd4,   32'h0000_0000, 1'b1, '{32'd0, ST_RANGE, 7'd4}},
         '{OP_POP_BACK,   7'd0,   32'h0000_0000, 1'b0, '0},
         '{OP_POP_FRONT,  7'd0,   32'h0000_0000, 1'b0, '0},
         '{OP_SPARE_LAST, 7'd1,   32'hFFFF_FFFF, 1'b1, '{32'd0, ST_OK,    7'd2}},
         '{OP_SPARE_FIRST,7'd0,   32'h0000_0000, 1'b0, '0},
         '{OP_CLEAR,      7'd0,   32'h0000_0000, 1'b1, '{32'd0, ST_OK,    7'd0}},
         '{OP_PUSH_FRONT, 7'd0,   32'h5555_AAAA, 1'b0, '0}
      };
      shadow_head = 0;
      shadow_count = 0;
      burst_left = $urandom_range(1, 40);
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < NUM_DIRECTED; k++)
         drive_item(directed_rows[k].op, directed_rows[k].pos, directed_rows[k].data,
                    directed_rows[k].typed, directed_rows[k].want);
      wait_all_returned();

      ph = PH_FILL;
      while (items_sent < NUM_ITEMS + NUM_DIRECTED) begin
         case (ph)
            PH_FILL: begin
               while (shadow_count < DEPTH) send_random(PH_FILL);
               // keep pushing and inserting against a full store
               extra = $urandom_range(3, 8);
               repeat (extra) send_random(PH_FILL);
            end
            PH_DRAIN: begin
               while (shadow_count > 0) send_random(PH_DRAIN);
               extra = $urandom_range(3, 8);
               repeat (extra) send_random(PH_DRAIN);
            end
            default: begin
               extra = $urandom_range(40, 150);
               repeat (extra) send_random(PH_MIX);
            end
         endcase
         k = $urandom_range(0, 9);
         ph = (k < 2) ? PH_FILL : (k < 4) ? PH_DRAIN : PH_MIX;
         if (ph == PH_FILL) wait_all_returned();
      end

      req_valid <= 1'b0;
      drain_cycles = 0;
      while (pending_results.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (MAX_SHIFT_CYCLES + 10) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
